// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLE_ASSERT_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define SLE_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/sle_pkg.sv =====
// Package of the sorted list engine: sizes, codes and cell control types.
// No dependencies.
`default_nettype none

package sle_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic               enable;
    logic               remove;
    logic signed [31:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic ge;
    logic hit;
  } cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/sle_ifs.sv =====
// Request and result channel interfaces of the sorted list engine.
// No dependencies.
`default_nettype none

interface sle_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] item_value;
  modport source (output valid, output cmd, output item_value, input ready);
  modport sink (input valid, input cmd, input item_value, output ready);
endinterface

interface sle_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [4:0]         entry_count;
  logic signed [31:0] smallest_value;
  modport source (output valid, output status, output entry_count, output smallest_value,
                  input ready);
  modport sink (input valid, input status, input entry_count, input smallest_value,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/sle_cell.sv =====
// One compare-and-shift cell of the sorted chain.
// Depends on sle_pkg.
`default_nettype none

module sle_cell (
  input  wire logic               clk,
  input  wire sle_pkg::cell_ctl_t ctl,
  input  wire logic               occupied,
  input  wire logic               left_ge,
  input  wire logic signed [31:0] left_value,
  input  wire logic signed [31:0] right_value,
  output logic signed [31:0]      value,
  output sle_pkg::cell_flags_t    flags
);

  logic ge;

  assign ge = !occupied || !(value < ctl.value);
  assign flags.ge = ge;
  assign flags.hit = occupied && ge && !left_ge && (value == ctl.value);

  always_ff @(posedge clk) begin
    if (ctl.enable && ge) begin
      if (ctl.remove) begin
        value <= right_value;
      end else begin
        value <= left_ge ? left_value : ctl.value;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_list_engine.sv =====
// Top level of the sorted list engine: a row of compare-and-shift cells,
// the entry counter and the result register. Depends on sle_pkg, sle_ifs, sle_cell.
//
//   channel  role    moves
//   req      sink    cmd, item_value
//   rsp      source  status, entry_count, smallest_value
//
// An insert (not full) or a remove (found) updates each cell that is empty or not
// below its item; its result shows on rsp in the next cycle. One request per cycle
// while rsp is taken, i.e. no result is pending or it is taken in the same cycle.
// Reset clears the count and the pending result; cell contents stay as they are.
`default_nettype none

module sorted_list_engine (
  input wire logic clk,
  input wire logic rst,
  sle_req_if.sink  req,
  sle_rsp_if.source rsp
);

  localparam int N = sle_pkg::CAPACITY;

  sle_pkg::count_t     count;
  sle_pkg::count_t     count_next;
  logic [1:0]          status;
  logic [1:0]          status_next;
  logic                rsp_valid;
  logic                accept;
  logic                full;
  logic                found;
  sle_pkg::cell_ctl_t  ctl;
  logic signed [31:0]  cell_value [N];
  sle_pkg::cell_flags_t cell_flags [N];
  logic [N-1:0]        hits;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept = req.valid && req.ready;
  assign full = (count == sle_pkg::count_t'(N));
  assign found = |hits;

  always_comb begin
    ctl.remove = (req.cmd == sle_pkg::CMD_REMOVE);
    ctl.value = req.item_value;
    ctl.enable = accept && (ctl.remove ? found : !full);
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic               occupied;
    logic               left_ge;
    logic signed [31:0] left_value;
    logic signed [31:0] right_value;

    assign occupied = (sle_pkg::count_t'(i) < count);
    assign hits[i] = cell_flags[i].hit;

    if (i == 0) begin : g_first
      assign left_ge = 1'b0;
      assign left_value = req.item_value;
    end else begin : g_inner
      assign left_ge = cell_flags[i-1].ge;
      assign left_value = cell_value[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    sle_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occupied),
      .left_ge     (left_ge),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[i]),
      .flags       (cell_flags[i])
    );
  end

  always_comb begin
    count_next = count;
    status_next = sle_pkg::ST_DONE;
    if (ctl.remove) begin
      if (found) begin
        count_next = count - sle_pkg::count_t'(1);
      end else begin
        status_next = sle_pkg::ST_NOT_FOUND;
      end
    end else begin
      if (full) begin
        status_next = sle_pkg::ST_FULL;
      end else begin
        count_next = count + sle_pkg::count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.status = status;
  assign rsp.entry_count = 5'(count);
  assign rsp.smallest_value = (count != '0) ? cell_value[0] : 32'sd0;

endmodule

`default_nettype wire

// ===== rtl/sle_checker.sv =====
// Port-level checks of the sorted list engine, bound to the top level.
// Depends on sle_pkg, assert_macros.svh, sorted_list_engine.
`default_nettype none
`include "assert_macros.svh"

module sle_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic [1:0]         rsp_status,
  input wire logic [4:0]         rsp_entry_count,
  input wire logic signed [31:0] rsp_smallest_value
);

  logic req_accept;
  logic rsp_stall;
  logic full_shown;
  logic at_capacity;
  logic empty_shown;
  logic zero_shown;

  assign req_accept = req_valid && req_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;
  assign full_shown = rsp_valid && (rsp_status == sle_pkg::ST_FULL);
  assign at_capacity = (rsp_entry_count == 5'(sle_pkg::CAPACITY));
  assign empty_shown = rsp_valid && (rsp_entry_count == 5'd0) && (sle_pkg::CAPACITY < 32);
  assign zero_shown = (rsp_smallest_value == 32'sd0);

  `SLE_ASSERT_IMPLY(a_no_overrun, clk, rst, req_accept, !rsp_stall, "request over stalled result")
  `SLE_ASSERT_NEXT(a_result_follows, clk, rst, req_accept, rsp_valid, "no result after request")
  `SLE_ASSERT_IMPLY(a_full_count, clk, rst, full_shown, at_capacity, "full with short count")
  `SLE_ASSERT_IMPLY(a_empty_zero, clk, rst, empty_shown, zero_shown, "empty with nonzero value")

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_entry_count    (rsp.entry_count),
  .rsp_smallest_value (rsp.smallest_value)
);

`default_nettype wire
